/* rtl/core/chroma_bilinear_motion_comp_macros.svh */
// Assertion macros shared by the chroma interpolator RTL.
`ifndef CHROMA_BILINEAR_MOTION_COMP_MACROS_SVH
`define CHROMA_BILINEAR_MOTION_COMP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication check, disabled while reset is high.
`define CBMC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbmc: same-cycle check failed");
// Next-cycle implication check, disabled while reset is high.
`define CBMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbmc: next-cycle check failed");
`else
`define CBMC_ASSERT_NOW(label, clk, rst, ante, cons)
`define CBMC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/cbmc_pkg.sv */
// Shared types, register codes and weight helper for the chroma interpolator.
package cbmc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_FRAC_X       = 2'd0;
  localparam logic [1:0] REG_FRAC_Y       = 2'd1;
  localparam logic [1:0] REG_AVERAGE_MODE = 2'd2;
  localparam logic [1:0] REG_WIDTH_SELECT = 2'd3;

  // Reset value of the width select register (eight pixels).
  localparam logic [1:0] WIDTH_SELECT_RESET = 2'd2;

  // Rounding offset of the bilinear sum.
  localparam logic [15:0] ROUND_OFFSET = 16'd32;

  // Everything the filter needs about one accepted source pixel.
  typedef struct packed {
    logic       has_out;
    logic       last;
    logic       avg;
    logic [6:0] wa;
    logic [6:0] wb;
    logic [6:0] wc;
    logic [6:0] wd;
    logic [7:0] left;
    logic [7:0] src;
    logic [7:0] prior;
  } cbmc_issue_t;

  // Product of two factors in the range 0..8; the result is at most 64.
  function automatic logic [6:0] cbmc_weight(input logic [3:0] p, input logic [3:0] q);
    logic [6:0] r;
    r = {3'b000, p} * {3'b000, q};
    return r;
  endfunction

endpackage

/* rtl/core/cbmc_row_mem.sv */
// Previous-row store: one write port, two registered read ports.
module cbmc_row_mem #(
  parameter int DEPTH = 9,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [7:0]    rdata0,
  output logic [7:0]    rdata1
);

  logic [7:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports return the old contents when read and write meet.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

/* rtl/core/cbmc_filter.sv */
// Bilinear weighting pipeline with optional averaging and output register.
`include "chroma_bilinear_motion_comp_macros.svh"
module cbmc_filter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cbmc_pkg::cbmc_issue_t issue,
  input  logic [7:0]           tl,
  input  logic [7:0]           tr,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,
  output logic                 m_tlast
);
  import cbmc_pkg::*;

  cbmc_issue_t s1;
  logic        v1;
  logic        v2;
  logic [14:0] pa, pb, pc, pd;
  logic        avg2;
  logic        last2;
  logic [7:0]  prior2;
  logic        out_ready;
  logic        r2;
  logic [15:0] sum;
  logic [7:0]  interp;
  logic [8:0]  avg_sum;
  logic [7:0]  pix;

  // Each stage moves when it is empty or the next one moves.
  assign out_ready = !m_tvalid || m_tready;
  assign r2        = !v2 || out_ready;
  assign in_ready  = !v1 || r2;

  // Stage 1 holds the sideband aligned with the memory read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid && issue.has_out;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1 <= issue;
    end
  end

  // Stage 2 registers the four weighted pixels.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      pa     <= 15'(s1.wa) * 15'(tl);
      pb     <= 15'(s1.wb) * 15'(tr);
      pc     <= 15'(s1.wc) * 15'(s1.left);
      pd     <= 15'(s1.wd) * 15'(s1.src);
      avg2   <= s1.avg;
      last2  <= s1.last;
      prior2 <= s1.prior;
    end
  end

  // Sum, round and scale down; the weights add to 64 so the result fits a byte.
  always_comb begin
    sum     = 16'(pa) + 16'(pb) + 16'(pc) + 16'(pd) + ROUND_OFFSET;
    interp  = sum[13:6];
    avg_sum = {1'b0, prior2} + {1'b0, interp} + 9'd1;
    pix     = avg2 ? avg_sum[8:1] : interp;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      m_tdata <= pix;
      m_tlast <= last2;
    end
  end

  `CBMC_ASSERT_NOW(a_stall_only_when_full, clk, rst, !in_ready, v1 && v2 && m_tvalid)
  `CBMC_ASSERT_NEXT(a_stage1_moves, clk, rst, v1 && r2, v2)
  `CBMC_ASSERT_NEXT(a_stage2_moves, clk, rst, v2 && out_ready, m_tvalid)

endmodule

/* rtl/core/chroma_bilinear_motion_comp.sv */
// Eighth-sample bilinear chroma interpolator: row tracking and top level.
// A result passes the row store read, the weighted product and the output registers in turn.
// Throughput: one source pixel per cycle while s_tready is high; both upper neighbors read at once.
// The row-end write of the last column uses the store's single write port in the following cycle.
// Reset (rst, synchronous, active high) clears pipeline valids, column count, left pixel, fraction
// and average registers, resets width select, sets the first-row flag; row store is not cleared.
`include "chroma_bilinear_motion_comp_macros.svh"
module chroma_bilinear_motion_comp #(
  parameter int MAX_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // [7:0] src_pixel, [15:8] prior_pixel
  input  logic        s_tlast,    // last_in_block
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [7:0] out_pixel
  output logic        m_tlast,    // last_out
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data
);
  import cbmc_pkg::*;

  localparam int DEPTH = MAX_WIDTH + 1;
  localparam int AW    = $clog2(DEPTH);

  logic [2:0]    frac_x;
  logic [2:0]    frac_y;
  logic          average_mode;
  logic [1:0]    width_select;

  logic [AW-1:0] col_count;
  logic          first_row;
  logic [7:0]    left_pixel;
  logic          pend_valid;
  logic [AW-1:0] pend_addr;
  logic [7:0]    pend_data;

  logic [4:0]    w_raw;
  logic [AW-1:0] blk_width;
  logic [AW-1:0] col_eff;
  logic [AW-1:0] addr_prev;
  logic          fire;
  logic          has_col;
  logic          row_end;
  logic [3:0]    nx, ny;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [7:0]    tl, tr;
  cbmc_issue_t   issue;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frac_x       <= 3'd0;
      frac_y       <= 3'd0;
      average_mode <= 1'b0;
      width_select <= WIDTH_SELECT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAC_X:       frac_x       <= cfg_data;
        REG_FRAC_Y:       frac_y       <= cfg_data;
        REG_AVERAGE_MODE: average_mode <= cfg_data[0];
        REG_WIDTH_SELECT: width_select <= cfg_data[1:0];
        default:          frac_x       <= frac_x;
      endcase
    end
  end

  // Block width, saturated to MAX_WIDTH, and the clamped column.
  always_comb begin
    w_raw     = 5'd2 << width_select;
    blk_width = (w_raw > 5'(MAX_WIDTH)) ? AW'(MAX_WIDTH) : AW'(w_raw);
    col_eff   = (col_count > blk_width) ? blk_width : col_count;
    addr_prev = col_eff - AW'(1);
    has_col   = col_eff != '0;
    row_end   = col_eff >= blk_width;
    fire      = s_tvalid && s_tready;
  end

  // Row store write port: the deferred last-column write goes first.
  always_comb begin
    mem_we    = pend_valid || (fire && has_col);
    mem_waddr = pend_valid ? pend_addr : addr_prev;
    mem_wdata = pend_valid ? pend_data : left_pixel;
  end

  // Weights and sideband for the filter.
  always_comb begin
    nx             = 4'd8 - {1'b0, frac_x};
    ny             = 4'd8 - {1'b0, frac_y};
    issue.has_out  = has_col && !first_row;
    issue.last     = s_tlast;
    issue.avg      = average_mode;
    issue.wa       = cbmc_weight(nx, ny);
    issue.wb       = cbmc_weight({1'b0, frac_x}, ny);
    issue.wc       = cbmc_weight(nx, {1'b0, frac_y});
    issue.wd       = cbmc_weight({1'b0, frac_x}, {1'b0, frac_y});
    issue.left     = left_pixel;
    issue.src      = s_tdata[7:0];
    issue.prior    = s_tdata[15:8];
  end

  // Column tracking, left pixel and the deferred row-end write.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      first_row  <= 1'b1;
      left_pixel <= 8'd0;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= fire && row_end;
      if (fire) begin
        left_pixel <= s_tdata[7:0];
        if (s_tlast) begin
          col_count <= '0;
          first_row <= 1'b1;
        end else if (row_end) begin
          col_count <= '0;
          first_row <= 1'b0;
        end else begin
          col_count <= col_eff + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && row_end) begin
      pend_addr <= col_eff;
      pend_data <= s_tdata[7:0];
    end
  end

  cbmc_row_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_row_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .re     (fire),
    .raddr0 (addr_prev),
    .raddr1 (col_eff),
    .rdata0 (tl),
    .rdata1 (tr)
  );

  cbmc_filter u_filter (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fire),
    .in_ready (s_tready),
    .issue    (issue),
    .tl       (tl),
    .tr       (tr),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  `CBMC_ASSERT_NEXT(a_pend_one_cycle, clk, rst, pend_valid, !pend_valid)
  `CBMC_ASSERT_NOW(a_no_write_clash, clk, rst, pend_valid && fire, !has_col)
  `CBMC_ASSERT_NOW(a_col_bound, clk, rst, 1'b1, col_count <= AW'(MAX_WIDTH))
  `CBMC_ASSERT_NEXT(a_last_restart, clk, rst, fire && s_tlast, col_count == '0 && first_row)

endmodule
